// ===== design/ttg_pkg.sv =====
`default_nettype none
package ttg_pkg;

  // Command codes
  localparam logic [2:0] CMD_UPDATE  = 3'd0;
  localparam logic [2:0] CMD_EXPIRE  = 3'd1;
  localparam logic [2:0] CMD_NEAREST = 3'd2;
  localparam logic [2:0] CMD_LATEST  = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  // Track state codes
  localparam logic [1:0] TRK_NONE    = 2'd0;
  localparam logic [1:0] TRK_TENT    = 2'd1;
  localparam logic [1:0] TRK_TRACKED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CONFIRM_HITS = 2'd0;
  localparam logic [1:0] CFG_GATE_ENTER   = 2'd1;
  localparam logic [1:0] CFG_GATE_EXIT    = 2'd2;
  localparam logic [1:0] CFG_MISS_LIMIT   = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  RST_CONFIRM_HITS = 8'd3;
  localparam logic [23:0] RST_GATE_ENTER   = 24'd12800;
  localparam logic [23:0] RST_GATE_EXIT    = 24'd15360;
  localparam logic [23:0] RST_MISS_LIMIT   = 24'd1000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  track_index;
    logic        sensor_source;
    logic [23:0] distance;
    logic [47:0] time_ms;
  } ttg_in_t;

  typedef struct packed {
    logic        state_changed;
    logic [1:0]  old_state;
    logic [1:0]  entry_status;
    logic        found;
    logic [5:0]  found_index;
    logic        found_source;
    logic [23:0] found_distance;
    logic [47:0] found_time;
  } ttg_out_t;

  // Stored fields of one table entry
  typedef struct packed {
    logic        source;
    logic [1:0]  state;
    logic [23:0] distance;
    logic [47:0] time_ms;
  } ttg_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ONE_RD,
    S_ONE_EX,
    S_SCAN,
    S_SCAN_END,
    S_FINISH
  } ttg_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cap_item;
    logic cnt_clr;
    logic cnt_inc;
    logic clr_wr;
    logic one_rd;
    logic one_ex;
    logic scan_rd;
    logic out_load;
  } ttg_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_last;
  } ttg_sts_t;

endpackage
`default_nettype wire

// ===== design/ttg_ctrl.sv =====
`default_nettype none
module ttg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ttg_pkg::ttg_ctl_t      ctl,
  input  wire ttg_pkg::ttg_sts_t sts
);
  import ttg_pkg::*;

  ttg_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_UPDATE, CMD_READ:                state_nxt = S_ONE_RD;
            CMD_EXPIRE, CMD_NEAREST, CMD_LATEST: state_nxt = S_SCAN;
            default:                             state_nxt = S_FINISH;
          endcase
        end
      end
      S_ONE_RD:   state_nxt = S_ONE_EX;
      S_ONE_EX:   state_nxt = S_FINISH;
      S_SCAN: begin
        if (sts.cnt_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_wr  = 1'b1;
        ctl.cnt_inc = 1'b1;
      end
      S_IDLE: begin
        ctl.cap_item = accept;
        ctl.cnt_clr  = accept;
      end
      S_ONE_RD: ctl.one_rd = 1'b1;
      S_ONE_EX: ctl.one_ex = 1'b1;
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
        ctl.cnt_inc = 1'b1;
      end
      S_SCAN_END: ;
      S_FINISH: ctl.out_load = out_free;
      default: ;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ttg_dpath.sv =====
`default_nettype none
module ttg_dpath #(
  parameter int TRACKS   = 64,
  parameter int HIT_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ttg_pkg::ttg_in_t  in_data,
  output ttg_pkg::ttg_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [23:0]       cfg_data,
  input  wire ttg_pkg::ttg_ctl_t ctl,
  output ttg_pkg::ttg_sts_t      sts
);
  import ttg_pkg::*;

  localparam int AW    = $clog2(TRACKS);
  localparam int ENT_W = $bits(ttg_entry_t);
  localparam int RW    = ENT_W + 1 + HIT_BITS;
  localparam int CW    = (HIT_BITS > 8) ? HIT_BITS : 8;

  // Configuration registers
  logic [7:0]  cfg_confirm_r;
  logic [23:0] cfg_enter_r;
  logic [23:0] cfg_exit_r;
  logic [23:0] cfg_miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_confirm_r <= RST_CONFIRM_HITS;
      cfg_enter_r   <= RST_GATE_ENTER;
      cfg_exit_r    <= RST_GATE_EXIT;
      cfg_miss_r    <= RST_MISS_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONFIRM_HITS: cfg_confirm_r <= cfg_data[7:0];
        CFG_GATE_ENTER:   cfg_enter_r   <= cfg_data;
        CFG_GATE_EXIT:    cfg_exit_r    <= cfg_data;
        CFG_MISS_LIMIT:   cfg_miss_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured item
  ttg_in_t item_r;
  always_ff @(posedge clk) begin
    if (ctl.cap_item) item_r <= in_data;
  end

  logic          in_range;
  logic [AW-1:0] idx_addr;
  logic          is_update, is_expire, is_nearest, is_latest;

  assign in_range   = (32'(item_r.track_index) < 32'(TRACKS));
  assign idx_addr   = AW'(item_r.track_index);
  assign is_update  = (item_r.cmd == CMD_UPDATE);
  assign is_expire  = (item_r.cmd == CMD_EXPIRE);
  assign is_nearest = (item_r.cmd == CMD_NEAREST);
  assign is_latest  = (item_r.cmd == CMD_LATEST);

  // Entry address counter, used by the clearing pass and by scans
  logic [AW-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.cnt_clr) begin
      cnt_r <= '0;
    end else if (ctl.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end
  assign sts.cnt_last = (cnt_r == AW'(TRACKS - 1));

  // Entry memory: row = {hits, valid, entry}
  logic [RW-1:0] mem [TRACKS];
  logic [RW-1:0] rd_row_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_row;

  assign rd_en   = ctl.one_rd || ctl.scan_rd;
  assign rd_addr = ctl.scan_rd ? cnt_r : idx_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    if (rd_en) rd_row_r <= mem[rd_addr];
  end

  // Scan read pipeline tag
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl.scan_rd;
    end
    rd_idx_r <= cnt_r;
  end

  ttg_entry_t          rd_ent;
  logic                rd_valid;
  logic [HIT_BITS-1:0] rd_hits;
  assign rd_ent   = ttg_entry_t'(rd_row_r[ENT_W-1:0]);
  assign rd_valid = rd_row_r[ENT_W];
  assign rd_hits  = rd_row_r[RW-1:ENT_W+1];

  // Update: new state and hit count
  logic [1:0]          old_st;
  logic [1:0]          new_st;
  logic [HIT_BITS-1:0] hits_n;
  ttg_entry_t          upd_ent;

  always_comb begin
    old_st = rd_valid ? rd_ent.state : TRK_NONE;
    hits_n = rd_hits;
    if (!item_r.sensor_source) begin
      if (rd_hits != '1) hits_n = rd_hits + HIT_BITS'(1);
      new_st = (CW'(hits_n) >= CW'(cfg_confirm_r)) ? TRK_TRACKED : TRK_TENT;
    end else if (item_r.distance <= cfg_enter_r) begin
      new_st = TRK_TRACKED;
    end else if (old_st == TRK_TRACKED && item_r.distance <= cfg_exit_r) begin
      new_st = TRK_TRACKED;
    end else begin
      new_st = TRK_NONE;
    end
    upd_ent.source   = item_r.sensor_source;
    upd_ent.state    = new_st;
    upd_ent.distance = item_r.distance;
    upd_ent.time_ms  = item_r.time_ms;
  end

  // Expire test: current time beyond entry time by more than the limit
  logic [48:0] age;
  logic        exp_hit;
  ttg_entry_t  exp_ent;
  assign age     = {1'b0, item_r.time_ms} - {1'b0, rd_ent.time_ms};
  assign exp_hit = rd_vld_r && is_expire && rd_valid && (rd_ent.state != TRK_NONE) &&
                   !age[48] && (age[47:0] > {24'd0, cfg_miss_r});
  always_comb begin
    exp_ent       = rd_ent;
    exp_ent.state = TRK_NONE;
  end

  // Memory write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_row  = '0;
    priority if (ctl.clr_wr) begin
      wr_en = 1'b1;
    end else if (ctl.one_ex && is_update && in_range) begin
      wr_en   = 1'b1;
      wr_addr = idx_addr;
      wr_row  = {hits_n, 1'b1, upd_ent};
    end else if (exp_hit) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r;
      wr_row  = {rd_hits, rd_valid, exp_ent};
    end
  end

  // Nearest / latest search
  logic          have_r;
  logic [AW-1:0] best_idx_r;
  ttg_entry_t    best_r;
  logic          cand;
  logic          better;

  always_comb begin
    cand   = rd_vld_r && rd_valid && (rd_ent.source == item_r.sensor_source);
    better = 1'b0;
    if (is_nearest) begin
      cand   = cand && (rd_ent.state != TRK_NONE);
      better = !have_r || (rd_ent.distance < best_r.distance);
    end else if (is_latest) begin
      better = !have_r || (rd_ent.time_ms > best_r.time_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.cap_item) begin
      have_r <= 1'b0;
    end else if (cand && better) begin
      have_r <= 1'b1;
    end
    if (cand && better) begin
      best_idx_r <= rd_idx_r;
      best_r     <= rd_ent;
    end
  end

  // Result of single-entry commands
  ttg_out_t res_r;
  ttg_out_t one_res;
  always_comb begin
    one_res = '0;
    if (in_range) begin
      if (is_update) begin
        one_res.state_changed = (old_st != new_st);
        one_res.old_state     = old_st;
        one_res.entry_status  = new_st;
      end else if (rd_valid) begin
        one_res.entry_status   = rd_ent.state;
        one_res.found          = 1'b1;
        one_res.found_index    = item_r.track_index;
        one_res.found_source   = rd_ent.source;
        one_res.found_distance = rd_ent.distance;
        one_res.found_time     = rd_ent.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_item) begin
      res_r <= '0;
    end else if (ctl.one_ex) begin
      res_r <= one_res;
    end
  end

  // Output register
  ttg_out_t out_r;
  ttg_out_t fin_res;
  always_comb begin
    fin_res = res_r;
    if ((is_nearest || is_latest) && have_r) begin
      fin_res                = '0;
      fin_res.entry_status   = best_r.state;
      fin_res.found          = 1'b1;
      fin_res.found_index    = 6'(best_idx_r);
      fin_res.found_source   = best_r.source;
      fin_res.found_distance = best_r.distance;
      fin_res.found_time     = best_r.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) out_r <= fin_res;
  end
  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== design/track_table_with_gating_unit.sv =====
`default_nettype none
// Sequence: after accept, an update or read passes through S_ONE_RD and S_ONE_EX
// to S_FINISH; expire, nearest and latest scan the table in S_SCAN, one table
// entry read per scan cycle, then pass through S_SCAN_END to S_FINISH. The block
// takes one item at a time and waits in S_FINISH while out_ready is held low.
// Reset: synchronous, active low; a clearing pass zeroes every entry (valid and
// hit count) while in_ready stays low.
module track_table_with_gating_unit #(
  parameter int TRACKS   = 64,
  parameter int HIT_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ttg_pkg::ttg_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ttg_pkg::ttg_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [23:0]      cfg_data
);
  import ttg_pkg::*;

  ttg_ctl_t ctl;
  ttg_sts_t sts;

  // Sequencer
  ttg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Table, config registers and result path
  ttg_dpath #(
    .TRACKS   (TRACKS),
    .HIT_BITS (HIT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ===== bench/track_table_checker.sv =====
`default_nettype none
module track_table_checker #(
  parameter int TRACKS   = 64,
  parameter int HIT_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire ttg_pkg::ttg_in_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire ttg_pkg::ttg_out_t out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [23:0]       cfg_data,
  output int                     mismatch_count,
  output int                     pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttg_pkg::*;

  localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

  // Shadow copy of the configuration registers
  logic [7:0]  confirm_hits;
  logic [23:0] gate_enter;
  logic [23:0] gate_exit;
  logic [23:0] miss_limit;

  // Shadow copy of the track table
  logic                tbl_valid  [TRACKS];
  logic                tbl_source [TRACKS];
  logic [1:0]          tbl_state  [TRACKS];
  logic [23:0]         tbl_dist   [TRACKS];
  logic [47:0]         tbl_time   [TRACKS];
  logic [HIT_BITS-1:0] tbl_hits   [TRACKS];

  ttg_out_t awaited_reports[$];
  ttg_out_t want;
  int       result_seq;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $time, result_seq, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [47:0] seen,
                             input logic [47:0] exp_val);
    if (seen !== exp_val)
      report_mismatch($sformatf("%s got %0h, want %0h", name, seen, exp_val));
  endtask

  // Result describing one stored entry
  function automatic ttg_out_t entry_report(input int i);
    ttg_out_t r;
    r                = '0;
    r.entry_status   = tbl_state[i];
    r.found          = 1'b1;
    r.found_index    = i[5:0];
    r.found_source   = tbl_source[i];
    r.found_distance = tbl_dist[i];
    r.found_time     = tbl_time[i];
    return r;
  endfunction

  // Apply one command to the shadow table and work out its result
  task automatic predict_table_op(input ttg_in_t it, output ttg_out_t r);
    int          idx;
    int          best;
    logic        have;
    logic [1:0]  prior;
    logic [1:0]  next_state;
    logic [47:0] age;
    r   = '0;
    idx = int'(it.track_index);
    case (it.cmd)
      CMD_UPDATE: begin
        if (idx < TRACKS) begin
          prior = tbl_valid[idx] ? tbl_state[idx] : TRK_NONE;
          if (!it.sensor_source) begin
            if (tbl_hits[idx] != HIT_MAX) tbl_hits[idx]++;
            next_state = (32'(tbl_hits[idx]) >= 32'(confirm_hits)) ? TRK_TRACKED : TRK_TENT;
          end else if (it.distance <= gate_enter) begin
            next_state = TRK_TRACKED;
          end else if (prior == TRK_TRACKED && it.distance <= gate_exit) begin
            next_state = TRK_TRACKED;
          end else begin
            next_state = TRK_NONE;
          end
          tbl_valid[idx]  = 1'b1;
          tbl_source[idx] = it.sensor_source;
          tbl_state[idx]  = next_state;
          tbl_dist[idx]   = it.distance;
          tbl_time[idx]   = it.time_ms;
          r.state_changed = (prior != next_state);
          r.old_state     = prior;
          r.entry_status  = next_state;
        end
      end
      CMD_EXPIRE: begin
        for (int i = 0; i < TRACKS; i++) begin
          if (tbl_valid[i] && tbl_state[i] != TRK_NONE && it.time_ms > tbl_time[i]) begin
            age = it.time_ms - tbl_time[i];
            if (age > {24'd0, miss_limit}) tbl_state[i] = TRK_NONE;
          end
        end
      end
      CMD_NEAREST, CMD_LATEST: begin
        have = 1'b0;
        best = 0;
        for (int i = 0; i < TRACKS; i++) begin
          if (!tbl_valid[i] || tbl_source[i] != it.sensor_source) continue;
          if (it.cmd == CMD_NEAREST) begin
            if (tbl_state[i] == TRK_NONE) continue;
            if (!have || tbl_dist[i] < tbl_dist[best]) begin
              best = i;
              have = 1'b1;
            end
          end else if (!have || tbl_time[i] > tbl_time[best]) begin
            best = i;
            have = 1'b1;
          end
        end
        if (have) r = entry_report(best);
      end
      CMD_READ: begin
        if (idx < TRACKS && tbl_valid[idx]) r = entry_report(idx);
      end
      default: ;
    endcase
  endtask

  // Track config writes, predict accepted items, compare accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      confirm_hits = RST_CONFIRM_HITS;
      gate_enter   = RST_GATE_ENTER;
      gate_exit    = RST_GATE_EXIT;
      miss_limit   = RST_MISS_LIMIT;
      for (int i = 0; i < TRACKS; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_hits[i]  = '0;
      end
      awaited_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CONFIRM_HITS: confirm_hits = cfg_data[7:0];
          CFG_GATE_ENTER:   gate_enter   = cfg_data;
          CFG_GATE_EXIT:    gate_exit    = cfg_data;
          CFG_MISS_LIMIT:   miss_limit   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_table_op(in_data, want);
        awaited_reports = {awaited_reports, want};
      end
      if (out_valid && out_ready) begin
        result_seq++;
        if (awaited_reports.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = awaited_reports.pop_front();
          check_field("state_changed", 48'(out_data.state_changed),
                      48'(want.state_changed));
          check_field("old_state", 48'(out_data.old_state), 48'(want.old_state));
          check_field("entry_status", 48'(out_data.entry_status),
                      48'(want.entry_status));
          check_field("found", 48'(out_data.found), 48'(want.found));
          check_field("found_index", 48'(out_data.found_index), 48'(want.found_index));
          check_field("found_source", 48'(out_data.found_source),
                      48'(want.found_source));
          check_field("found_distance", 48'(out_data.found_distance),
                      48'(want.found_distance));
          check_field("found_time", out_data.found_time, want.found_time);
        end
      end
    end
    pending_results = awaited_reports.size();
  end

endmodule
`default_nettype wire

// ===== bench/tb_track_table_with_gating_unit.sv =====
`default_nettype none
module tb_track_table_with_gating_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ttg_pkg::*;

  localparam int TRACKS     = 64;
  localparam int HIT_BITS   = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 50;

  // Command codes the block ignores
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  ttg_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ttg_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data  = '0;

  int mismatch_count;
  int pending_results;
  int tx_idle_pct = 30;
  int rx_idle_pct = 74;
  int idle_cycles = 0;

  logic [47:0]       clock_ms  = '0;
  logic [23:0]       cur_enter = RST_GATE_ENTER;
  logic [23:0]       cur_exit  = RST_GATE_EXIT;
  logic [TRACKS-1:0] touched   = '0;

  always #4 clk = ~clk;

  track_table_with_gating_unit #(
    .TRACKS   (TRACKS),
    .HIT_BITS (HIT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  track_table_checker #(
    .TRACKS   (TRACKS),
    .HIT_BITS (HIT_BITS)
  ) u_track_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
          $display("track_table_with_gating_unit test failed");
          $finish;
        end
      end
    end
  end

  function automatic ttg_in_t mk_item(input logic [2:0] c, input logic [5:0] idx,
                                      input logic src, input logic [23:0] d,
                                      input logic [47:0] t);
    ttg_in_t it;
    it.cmd           = c;
    it.track_index   = idx;
    it.sensor_source = src;
    it.distance      = d;
    it.time_ms       = t;
    return it;
  endfunction

  // Offer one item, with a random idle gap ahead of it
  task automatic send_item(input ttg_in_t it);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < tx_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.cmd == CMD_UPDATE) touched[it.track_index] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_config(input logic [7:0] hits, input logic [23:0] enter_d,
                            input logic [23:0] exit_d, input logic [23:0] miss);
    drain_results();
    write_reg(CFG_CONFIRM_HITS, {16'd0, hits});
    write_reg(CFG_GATE_ENTER, enter_d);
    write_reg(CFG_GATE_EXIT, exit_d);
    write_reg(CFG_MISS_LIMIT, miss);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_enter = enter_d;
    cur_exit  = exit_d;
  endtask

  // Random command; indexes mostly in a small set so entries get revisited
  function automatic ttg_in_t random_item();
    ttg_in_t it;
    int      roll;
    roll = $urandom_range(99);
    if (roll < 50)      it.cmd = CMD_UPDATE;
    else if (roll < 60) it.cmd = CMD_EXPIRE;
    else if (roll < 71) it.cmd = CMD_NEAREST;
    else if (roll < 82) it.cmd = CMD_LATEST;
    else if (roll < 96) it.cmd = CMD_READ;
    else                it.cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    it.track_index = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(7));
    it.sensor_source = 1'($urandom_range(1));
    case ($urandom_range(3))
      0:       it.distance = cur_enter + 24'($urandom_range(4)) - 24'd2;
      1:       it.distance = cur_exit + 24'($urandom_range(4)) - 24'd2;
      2:       it.distance = 24'($urandom_range(40000));
      default: it.distance = 24'($urandom);
    endcase
    it.time_ms = 48'({$urandom, $urandom});
    if (it.cmd == CMD_UPDATE && $urandom_range(9) != 0) begin
      clock_ms   = clock_ms + 48'($urandom_range(600));
      it.time_ms = clock_ms;
    end
    if (it.cmd == CMD_EXPIRE && $urandom_range(7) != 0)
      it.time_ms = clock_ms + 48'($urandom_range(1500));
    // never read an entry that was never written
    if (it.cmd == CMD_READ && !touched[it.track_index]) it.cmd = CMD_LATEST;
    return it;
  endfunction

  task automatic random_phase(input int count);
    repeat (count) begin
      if ($urandom_range(99) < 3) drain_results();
      send_item(random_item());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_config(RST_CONFIRM_HITS, RST_GATE_ENTER, RST_GATE_EXIT, RST_MISS_LIMIT);

    // Directed: empty searches, confirmation, gate edges, ties, expiry edge
    send_item(mk_item(CMD_NEAREST, 6'd0, 1'b0, 24'd0, 48'd0));
    send_item(mk_item(CMD_LATEST, 6'd63, 1'b1, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF));
    send_item(mk_item(CMD_UPDATE, 6'd0, 1'b0, 24'd0, 48'd100));
    send_item(mk_item(CMD_UPDATE, 6'd0, 1'b0, 24'hFFFFFF, 48'd200));
    send_item(mk_item(CMD_UPDATE, 6'd0, 1'b0, 24'd1234, 48'd300));
    send_item(mk_item(CMD_UPDATE, 6'd63, 1'b1, 24'd12800, 48'd400));
    send_item(mk_item(CMD_UPDATE, 6'd63, 1'b1, 24'd15360, 48'd500));
    send_item(mk_item(CMD_UPDATE, 6'd63, 1'b1, 24'd15361, 48'd550));
    send_item(mk_item(CMD_UPDATE, 6'd63, 1'b1, 24'd15360, 48'd560));
    send_item(mk_item(CMD_UPDATE, 6'd62, 1'b1, 24'd12801, 48'd570));
    send_item(mk_item(CMD_UPDATE, 6'd1, 1'b1, 24'd100, 48'hFFFF_FFFF_FFFF));
    send_item(mk_item(CMD_UPDATE, 6'd2, 1'b1, 24'd100, 48'd600));
    send_item(mk_item(CMD_NEAREST, 6'd0, 1'b1, 24'd0, 48'd0));
    send_item(mk_item(CMD_LATEST, 6'd0, 1'b1, 24'd0, 48'd0));
    send_item(mk_item(CMD_READ, 6'd63, 1'b0, 24'd0, 48'd0));
    // an entry stamped later than now never expires
    send_item(mk_item(CMD_EXPIRE, 6'd0, 1'b0, 24'd0, 48'd1300));
    send_item(mk_item(CMD_EXPIRE, 6'd0, 1'b0, 24'd0, 48'd1301));
    send_item(mk_item(CMD_NEAREST, 6'd0, 1'b0, 24'd0, 48'd0));
    send_item(mk_item(CMD_LATEST, 6'd0, 1'b0, 24'd0, 48'd0));
    send_item(mk_item(CMD_SPARE_LO, 6'd63, 1'b1, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF));
    send_item(mk_item(CMD_SPARE_MID, 6'd21, 1'b0, 24'h5A5A5A, 48'h5555_5555_5555));
    send_item(mk_item(CMD_SPARE_HI, 6'd42, 1'b1, 24'hA5A5A5, 48'hAAAA_AAAA_AAAA));
    send_item(mk_item(CMD_UPDATE, 6'd0, 1'b0, 24'd50, 48'd1400));
    send_item(mk_item(CMD_UPDATE, 6'd2, 1'b0, 24'd60, 48'd1500));
    send_item(mk_item(CMD_UPDATE, 6'd0, 1'b1, 24'd20000, 48'd1600));
    send_item(mk_item(CMD_READ, 6'd0, 1'b0, 24'd0, 48'd0));

    clock_ms = 48'd10000;

    // Sender idles 30%, receiver 74%; extreme gates and limits
    tx_idle_pct = 30;
    rx_idle_pct = 74;
    set_config(8'd1, 24'd0, 24'hFFFFFF, 24'd0);
    random_phase(PHASE_ITEMS);

    // Sender idles 74%, receiver 30%
    tx_idle_pct = 74;
    rx_idle_pct = 30;
    set_config(8'($urandom_range(6, 2)), 24'($urandom_range(16000, 2000)),
               cur_enter + 24'($urandom_range(6000)), 24'($urandom_range(3000, 300)));
    set_config(8'($urandom_range(6, 2)), cur_enter, cur_enter + 24'($urandom_range(6000)),
               24'($urandom_range(3000, 300)));
    random_phase(PHASE_ITEMS);

    // No idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(8'($urandom_range(5, 1)), 24'($urandom_range(16000, 2000)),
               24'($urandom_range(20000, 1000)), 24'($urandom_range(2000, 100)));
    random_phase(PHASE_ITEMS);

    // Drive one entry's hit count up to the largest threshold and into saturation
    set_config(8'd255, 24'hFFFFFF, 24'd0, 24'hFFFFFF);
    repeat (258) begin
      clock_ms = clock_ms + 48'd1;
      send_item(mk_item(CMD_UPDATE, 6'd9, 1'b0, 24'($urandom), clock_ms));
    end
    send_item(mk_item(CMD_READ, 6'd9, 1'b0, 24'd0, 48'd0));

    // Zero threshold and fully random gates
    set_config(8'd0, 24'($urandom), 24'($urandom), 24'($urandom));
    random_phase(20);

    drain_results();
    repeat (TRACKS + 8) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("track_table_with_gating_unit test passed");
    end else begin
      $display("track_table_with_gating_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/ttg_pkg.sv
design/ttg_ctrl.sv
design/ttg_dpath.sv
design/track_table_with_gating_unit.sv
bench/track_table_checker.sv
bench/tb_track_table_with_gating_unit.sv
